### design/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants for the fit policy block allocator
// Table size, field widths, placement mode and request type codes and the compare result.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int NUM_BLOCKS = 8;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  localparam int AMT_W  = 16;
  localparam int BLK_W  = 3;
  localparam int TOT_W  = 19;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef logic [AMT_W-1:0] cap_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic fits;
    logic take;
  } cmp_res_t;

endpackage

### design/fpba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fpba_ram #(
  parameter int W = 16,
  parameter int D = 8
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                      wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fpba_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_cmp: shared fit compare unit
// Decides whether one table entry fits the request and beats the current pick.
// ----------------------------------------------------------------------------
module fpba_cmp (
  input  logic [fpba_pkg::MODE_W-1:0] mode,
  input  fpba_pkg::cap_t              need,
  input  fpba_pkg::cap_t              cap,
  input  logic                        found,
  input  fpba_pkg::cap_t              best_cap,
  output fpba_pkg::cmp_res_t          res
);

  logic smaller;
  logic larger;

  assign smaller = cap < best_cap;
  assign larger  = cap > best_cap;

  always_comb begin
    res.fits = cap >= need;
    res.take = 1'b0;
    if (res.fits) begin
      if (!found) begin
        res.take = 1'b1;
      end else begin
        case (mode)
          fpba_pkg::MODE_BEST:  res.take = smaller;
          fpba_pkg::MODE_WORST: res.take = larger;
          // first fit keeps the lowest index, also for the unused code
          default:              res.take = 1'b0;
        endcase
      end
    end
  end

endmodule

### design/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: first, best or worst fit block allocation
// Keeps free capacities of a block table, loads entries and places requests.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   in      | in_req_type, in_block_index, in_amount  | start && !busy
//   out     | out_granted, out_chosen_block,          | out_valid, 1 cycle,
//           | out_block_remaining, out_total_free     | cannot be stalled
//   cfg     | cfg_wdata (fit mode)                    | cfg_we
//
// a load item keeps busy high through the load state, which registers its result
// an allocate item keeps busy high through the scan, drain and write states:
// one compare unit walks the table through the single ram read port, one
// entry per cycle, then the write state writes back the updated capacity
// reset clears the table through per-entry valid bits, so no clearing pass
// the result is shown once with out_valid; busy is low in that same cycle
// ----------------------------------------------------------------------------
module fit_policy_block_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [fpba_pkg::BLK_W-1:0]   in_block_index,
  input  logic [fpba_pkg::AMT_W-1:0]   in_amount,
  output logic                         out_valid,
  output logic                         out_granted,
  output logic [fpba_pkg::BLK_W-1:0]   out_chosen_block,
  output logic [fpba_pkg::AMT_W-1:0]   out_block_remaining,
  output logic [fpba_pkg::TOT_W-1:0]   out_total_free,
  input  logic                         cfg_we,
  input  logic [fpba_pkg::MODE_W-1:0]  cfg_wdata
);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] S_LOAD  = 3'd1;
  localparam logic [STATE_W-1:0] S_SCAN  = 3'd2;
  localparam logic [STATE_W-1:0] S_DRAIN = 3'd3;
  localparam logic [STATE_W-1:0] S_WRITE = 3'd4;

  localparam fpba_pkg::idx_t LAST_IDX = fpba_pkg::IDX_W'(fpba_pkg::NUM_BLOCKS - 1);

  logic [STATE_W-1:0]              state_r, state_nxt;
  logic [fpba_pkg::MODE_W-1:0]     mode_r, mode_nxt;
  fpba_pkg::cap_t                  amt_r, amt_nxt;
  logic [fpba_pkg::BLK_W-1:0]      req_idx_r, req_idx_nxt;
  logic                            ld_ok_r, ld_ok_nxt;
  fpba_pkg::idx_t                  cnt_r, cnt_nxt;
  logic                            rd_v_r, rd_v_nxt;
  fpba_pkg::idx_t                  rd_idx_r, rd_idx_nxt;
  logic                            found_r, found_nxt;
  fpba_pkg::idx_t                  best_idx_r, best_idx_nxt;
  fpba_pkg::cap_t                  best_cap_r, best_cap_nxt;
  logic [fpba_pkg::TOT_W-1:0]      total_r, total_nxt;
  logic [fpba_pkg::NUM_BLOCKS-1:0] valid_r, valid_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_granted_r, out_granted_nxt;
  logic [fpba_pkg::BLK_W-1:0]      out_chosen_r, out_chosen_nxt;
  fpba_pkg::cap_t                  out_remain_r, out_remain_nxt;
  logic [fpba_pkg::TOT_W-1:0]      out_total_r, out_total_nxt;

  logic                            accept;
  fpba_pkg::idx_t                  ram_raddr;
  fpba_pkg::cap_t                  ram_rdata;
  logic                            ram_we;
  fpba_pkg::idx_t                  ram_waddr;
  fpba_pkg::cap_t                  ram_wdata;
  fpba_pkg::cap_t                  cur_cap;
  fpba_pkg::cmp_res_t              cmp_res;

  assign busy   = state_r != S_IDLE;
  assign accept = start && (state_r == S_IDLE);

  assign ram_raddr = (state_r == S_SCAN) ? cnt_r : fpba_pkg::IDX_W'(in_block_index);
  // entries never written since reset read as empty
  assign cur_cap   = valid_r[rd_idx_r] ? ram_rdata : '0;

  fpba_ram #(
    .W (fpba_pkg::AMT_W),
    .D (fpba_pkg::NUM_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpba_cmp u_cmp (
    .mode     (mode_r),
    .need     (amt_r),
    .cap      (cur_cap),
    .found    (found_r),
    .best_cap (best_cap_r),
    .res      (cmp_res)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = cfg_we ? cfg_wdata : mode_r;
    amt_nxt        = amt_r;
    req_idx_nxt    = req_idx_r;
    ld_ok_nxt      = ld_ok_r;
    cnt_nxt        = cnt_r;
    rd_v_nxt       = 1'b0;
    rd_idx_nxt     = ram_raddr;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_cap_nxt   = best_cap_r;
    total_nxt      = total_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_granted_nxt = out_granted_r;
    out_chosen_nxt = out_chosen_r;
    out_remain_nxt = out_remain_r;
    out_total_nxt  = out_total_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_idx_r;
    ram_wdata      = amt_r;

    // compare stage follows the registered ram read
    if (rd_v_r && cmp_res.take) begin
      found_nxt    = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_cap_nxt = cur_cap;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          amt_nxt     = in_amount;
          req_idx_nxt = in_block_index;
          ld_ok_nxt   = 32'(in_block_index) < fpba_pkg::NUM_BLOCKS;
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          state_nxt   = (in_req_type == fpba_pkg::REQ_LOAD) ? S_LOAD : S_SCAN;
        end
      end
      S_LOAD: begin
        if (ld_ok_r) begin
          ram_we              = 1'b1;
          ram_waddr           = rd_idx_r;
          ram_wdata           = amt_r;
          valid_nxt[rd_idx_r] = 1'b1;
          total_nxt = fpba_pkg::TOT_W'(total_r + fpba_pkg::TOT_W'(amt_r)
                                       - fpba_pkg::TOT_W'(cur_cap));
        end
        out_valid_nxt   = 1'b1;
        out_granted_nxt = 1'b0;
        out_chosen_nxt  = req_idx_r;
        out_remain_nxt  = ld_ok_r ? amt_r : '0;
        out_total_nxt   = total_nxt;
        state_nxt       = S_IDLE;
      end
      S_SCAN: begin
        rd_v_nxt = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        out_valid_nxt = 1'b1;
        if (found_r) begin
          ram_we                = 1'b1;
          ram_waddr             = best_idx_r;
          ram_wdata             = best_cap_r - amt_r;
          valid_nxt[best_idx_r] = 1'b1;
          total_nxt       = fpba_pkg::TOT_W'(total_r - fpba_pkg::TOT_W'(amt_r));
          out_granted_nxt = 1'b1;
          out_chosen_nxt  = fpba_pkg::BLK_W'(best_idx_r);
          out_remain_nxt  = best_cap_r - amt_r;
        end else begin
          out_granted_nxt = 1'b0;
          out_chosen_nxt  = '0;
          out_remain_nxt  = '0;
        end
        out_total_nxt = total_nxt;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= fpba_pkg::MODE_FIRST;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      total_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      out_total_r <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      total_r     <= total_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      out_total_r <= out_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_r         <= amt_nxt;
    req_idx_r     <= req_idx_nxt;
    ld_ok_r       <= ld_ok_nxt;
    cnt_r         <= cnt_nxt;
    rd_idx_r      <= rd_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_cap_r    <= best_cap_nxt;
    out_granted_r <= out_granted_nxt;
    out_chosen_r  <= out_chosen_nxt;
    out_remain_r  <= out_remain_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_granted         = out_granted_r;
  assign out_chosen_block    = out_chosen_r;
  assign out_block_remaining = out_remain_r;
  assign out_total_free      = out_total_r;

endmodule

### design/fpba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_checker: port-level checks for the fit policy block allocator
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module fpba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [fpba_pkg::TOT_W-1:0]  out_total_free
);

  // an accepted item always raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // a result is only shown once the block has gone idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe while busy or without a preceding item");

  // every finished item ends with its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // total only changes along with a result
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_valid |-> $stable(out_total_free))
    else $error("total free changed without a result");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_total_free (out_total_free)
);
